[rtl/mlr_pkg.sv]
// mlr_pkg: shared constants and types for the midpoint line rasterizer
// used by mlr_step and midpoint_line_rasterizer_unit; no dependencies
package mlr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int DELTA_BITS   = COORD_BITS + 1;
	localparam int DEC_BITS     = COORD_BITS + 4;
	localparam int S_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t                    major_pos;
		coord_t                    minor_pos;
		coord_t                    major_stop;
		logic signed [DEC_BITS-1:0] decision_term;
		logic [DELTA_BITS-1:0]     minor_delta;
		logic [DELTA_BITS-1:0]     major_delta;
		logic                      steep_flag;
		logic                      falling_flag;
		logic                      line_active;
	} mlr_state_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   pixel_valid;
		logic   last_pixel;
	} mlr_pixel_t;

endpackage

[rtl/mlr_step.sv]
// mlr_step: line setup and one midpoint step, next state and pixel for one item
// depends on mlr_pkg
module mlr_step (
	input  logic                command,
	input  mlr_pkg::coord_t     start_x,
	input  mlr_pkg::coord_t     start_y,
	input  mlr_pkg::coord_t     end_x,
	input  mlr_pkg::coord_t     end_y,
	input  mlr_pkg::mlr_state_t state_cur,
	output mlr_pkg::mlr_state_t state_nxt,
	output mlr_pkg::mlr_pixel_t pixel
);
	import mlr_pkg::*;

	coord_t                adx, ady;
	logic                  steep;
	coord_t                sa0, sb0, sa1, sb1;
	coord_t                a0, b0, a1, b1;
	logic                  falling;
	logic [DELTA_BITS-1:0] maj_d, min_d;
	logic [DEC_BITS-1:0]   maj_ext, min2, maj2;
	logic [DEC_BITS-1:0]   cur_maj2, cur_min2;
	mlr_state_t            setup_st, adv_st, nxt;
	logic                  last;

	// line setup
	always_comb begin
		adx   = (end_x > start_x) ? end_x - start_x : start_x - end_x;
		ady   = (end_y > start_y) ? end_y - start_y : start_y - end_y;
		steep = adx < ady;
		sa0   = steep ? start_y : start_x;
		sb0   = steep ? start_x : start_y;
		sa1   = steep ? end_y : end_x;
		sb1   = steep ? end_x : end_y;
		if (sa0 > sa1) begin
			a0 = sa1;
			b0 = sb1;
			a1 = sa0;
			b1 = sb0;
		end else begin
			a0 = sa0;
			b0 = sb0;
			a1 = sa1;
			b1 = sb1;
		end
		falling = !(b0 < b1);
		maj_d   = DELTA_BITS'(a1 - a0);
		min_d   = falling ? DELTA_BITS'(b0 - b1) : DELTA_BITS'(b1 - b0);
		maj_ext = DEC_BITS'(maj_d);
		min2    = DEC_BITS'(min_d) << 1;

		setup_st.steep_flag    = steep;
		setup_st.falling_flag  = falling;
		setup_st.major_delta   = maj_d;
		setup_st.minor_delta   = min_d;
		setup_st.major_pos     = falling ? a1 : a0;
		setup_st.minor_pos     = falling ? b1 : b0;
		setup_st.major_stop    = falling ? a0 : a1;
		setup_st.decision_term = $signed(maj_ext - min2);
		setup_st.line_active   = 1'b1;
	end

	// one step along the major axis
	always_comb begin
		cur_maj2 = DEC_BITS'(state_cur.major_delta) << 1;
		cur_min2 = DEC_BITS'(state_cur.minor_delta) << 1;
		maj2     = cur_maj2 - cur_min2;
		adv_st   = state_cur;
		adv_st.major_pos = state_cur.falling_flag ? state_cur.major_pos - 1'b1
			: state_cur.major_pos + 1'b1;
		if (state_cur.decision_term < 0) begin
			adv_st.minor_pos     = state_cur.minor_pos + 1'b1;
			adv_st.decision_term = $signed(DEC_BITS'(state_cur.decision_term) + maj2);
		end else begin
			adv_st.decision_term = $signed(DEC_BITS'(state_cur.decision_term) - cur_min2);
		end
	end

	always_comb begin
		nxt   = (command == CMD_START) ? setup_st : adv_st;
		last  = nxt.major_pos == nxt.major_stop;
		pixel = '0;
		if (command == CMD_START || state_cur.line_active) begin
			nxt.line_active   = !last;
			state_nxt         = nxt;
			pixel.pixel_x     = nxt.steep_flag ? nxt.minor_pos : nxt.major_pos;
			pixel.pixel_y     = nxt.steep_flag ? nxt.major_pos : nxt.minor_pos;
			pixel.pixel_valid = 1'b1;
			pixel.last_pixel  = last;
		end else begin
			state_nxt = state_cur;
		end
	end

endmodule

[rtl/midpoint_line_rasterizer_unit.sv]
// midpoint_line_rasterizer_unit: top level of the midpoint line rasterizer
// depends on mlr_pkg and mlr_step
//
// Takes one command item per clock while s_tready is high and returns one pixel item per command.
// A start command (tuser 0) sets up the line from its two endpoints and
// returns the first pixel; an advance command (tuser 1) returns the next
// pixel, or an item with tuser 0 (no pixel) when no line is active. tlast
// marks the final pixel of a line. Setup or step plus the state update are
// combinational from the input handshake into the line state and the output
// register, so the result appears in the cycle after acceptance and the block
// sustains one item per clock while m_tready takes the output; s_tready is low only
// while the output register holds an item that m_tready does not take.
module midpoint_line_rasterizer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mlr_pkg::S_TDATA_BITS-1:0] s_tdata,  // start_x, start_y, end_x, end_y
	input  logic                             s_tuser,  // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mlr_pkg::M_TDATA_BITS-1:0] m_tdata,  // pixel_x, pixel_y
	output logic                             m_tuser,  // pixel_valid
	output logic                             m_tlast
);
	import mlr_pkg::*;

	mlr_state_t state_q, state_nxt;
	mlr_pixel_t pixel, pixel_q;
	logic       m_tvalid_q;
	logic       accept;

	mlr_step u_step (
		.command   (s_tuser),
		.start_x   (s_tdata[COORD_BITS-1:0]),
		.start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.pixel     (pixel)
	);

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_q <= pixel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_BITS'({pixel_q.pixel_y, pixel_q.pixel_x});
	assign m_tuser  = pixel_q.pixel_valid;
	assign m_tlast  = pixel_q.last_pixel;

endmodule
